// ===== hdl/ocht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered chained hash table package
// Field widths, operation codes and status codes shared by the design files.
// ----------------------------------------------------------------------------
package ocht_pkg;

	localparam int KEY_W  = 40;
	localparam int TAG_W  = 64;
	localparam int SEL_W  = 8;
	localparam int BC_W   = 9;
	localparam int CNT_W  = 11;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	localparam int IN_W   = 112;
	localparam int OUT_W  = 88;

	// Operation codes carried in the input item's tuser.
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// Register byte addresses.
	localparam logic [1:0] ADDR_BUCKET_COUNT = 2'd0;

endpackage

// ===== hdl/ocht_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key modulo unit
// Restoring remainder unit: one key bit per cycle, remainder ready with a
// one-cycle done pulse.
// ----------------------------------------------------------------------------
module ocht_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ocht_pkg::KEY_W-1:0] dividend,
	input  logic [ocht_pkg::BC_W-1:0]  divisor,
	output logic                      done,
	output logic [ocht_pkg::BC_W-1:0]  rem
);
	import ocht_pkg::*;

	localparam int CW = $clog2(KEY_W);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [KEY_W-1:0] num_q;
	logic [BC_W-1:0]  rem_q;
	logic [BC_W:0]    trial;
	logic [BC_W:0]    diff;
	logic             ge;

	// One subtract and compare per cycle.
	assign trial = {rem_q, num_q[KEY_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// Iteration control and remainder register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			rem_q <= ge ? diff[BC_W-1:0] : trial[BC_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/ordered_chained_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered chained hash table
// Keys with caller tags in bucket chains kept in ascending key order, nodes
// drawn from a shared pool, lowest free node first.
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  tuser func; tdata key, caller_tag, select
// m_*      out  m_tvalid/m_tready  tdata success, status, caller, bucket, count
// apb      in   psel/penable       bucket_count at byte address 0
//
// Insert, search and delete run the serial key modulo and then walk the chain
// through the single-port node memories; a count walks the selected bucket's
// chain directly. An insert then scans free-map words (up to POOL_NODES/32)
// for a free node. After reset, a bucket_count write and a clear, a sweep
// over max(MAX_BUCKETS, POOL_NODES/32) bucket heads and free-map words runs
// with s_tready low. A result waits in the output register; the next item is
// taken meanwhile.
// ----------------------------------------------------------------------------
module ordered_chained_hash_table #(
	parameter int MAX_BUCKETS = 256,
	parameter int POOL_NODES  = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ocht_pkg::IN_W-1:0]    s_tdata,  // key[39:0], caller_tag, bucket_select
	input  logic [ocht_pkg::FUNC_W-1:0]  s_tuser,  // func
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ocht_pkg::OUT_W-1:0]   m_tdata,  // success, status, found_caller,
	                                               // bucket_index, element_count, pad
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [1:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ocht_pkg::*;

	localparam int NI      = $clog2(POOL_NODES);
	localparam int PW      = NI + 1;
	localparam int HB      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int NWORDS  = (POOL_NODES + 31) / 32;
	localparam int WI      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SWEEP_N = (MAX_BUCKETS > NWORDS) ? MAX_BUCKETS : NWORDS;
	localparam int CW      = $clog2(SWEEP_N + 1);
	localparam int SW      = $clog2(POOL_NODES + 1);
	localparam int XW      = NI + 5;
	localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_DIV, S_HEAD, S_HWAIT, S_NRD, S_NCHK, S_FRD, S_FCHK,
		S_INS1, S_INS2, S_FREL_RD, S_FREL_WR, S_RESP
	} state_t;

	state_t            state_q;
	logic              clr_pend_q;
	logic              clr_rsp_q;
	logic [CW-1:0]     sweep_q;
	logic [BC_W-1:0]   bc_q;
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [TAG_W-1:0]  tag_q;
	logic [BC_W-1:0]   h_q;
	logic [PW-1:0]     cur_q;
	logic [PW-1:0]     prev_q;
	logic [PW-1:0]     n_q;
	logic [SW-1:0]     steps_q;
	logic [WI-1:0]     w_q;
	logic              succ_q;
	logic [STAT_W-1:0] stat_q;
	logic [TAG_W-1:0]  found_q;
	logic [SEL_W-1:0]  bidx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// Memories and their ports.
	logic [PW-1:0]    heads [MAX_BUCKETS];
	logic [KEY_W-1:0] key_mem [POOL_NODES];
	logic [TAG_W-1:0] tag_mem [POOL_NODES];
	logic [PW-1:0]    link_mem [POOL_NODES];
	logic [31:0]      free_mem [NWORDS];

	logic             hd_we;
	logic [HB-1:0]    hd_wa;
	logic [PW-1:0]    hd_wd;
	logic [PW-1:0]    hd_rd;
	logic             nd_we;
	logic             ln_we;
	logic [NI-1:0]    ln_wa;
	logic [PW-1:0]    ln_wd;
	logic [KEY_W-1:0] key_rd;
	logic [TAG_W-1:0] tag_rd;
	logic [PW-1:0]    link_rd;
	logic             fw_we;
	logic [WI-1:0]    fw_wa;
	logic [31:0]      fw_wd;
	logic [WI-1:0]    fw_ra;
	logic [31:0]      fw_rd;

	logic             cfg_we;
	logic             accept;
	logic             div_start;
	logic             div_done;
	logic [BC_W-1:0]  div_rem;
	logic [KEY_W-1:0] in_key;
	logic [TAG_W-1:0] in_tag;
	logic [SEL_W-1:0] in_sel;
	logic             cur_ok;
	logic             prev_ok;
	logic             walk_end;
	logic             key_eq;
	logic             key_lt;
	logic [XW-1:0]    cur_x;
	logic [WI-1:0]    cur_word;
	logic [4:0]       cur_bit;
	logic [4:0]       low_bit;
	logic [31:0]      clr_mask;
	logic [CW+4:0]    sweep_base;

	// Lowest set bit of a free-map word.
	function automatic logic [4:0] lowest_one(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	assign in_key = s_tdata[KEY_W-1:0];
	assign in_tag = s_tdata[KEY_W+TAG_W-1:KEY_W];
	assign in_sel = s_tdata[KEY_W+TAG_W+SEL_W-1:KEY_W+TAG_W];

	assign s_tready  = (state_q == S_IDLE) && !clr_pend_q;
	assign accept    = s_tvalid && s_tready;
	assign div_start = accept && (s_tuser <= FN_DELETE);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == ADDR_BUCKET_COUNT);
	assign prdata = (paddr == ADDR_BUCKET_COUNT) ? {{(32-BC_W){1'b0}}, bc_q} : '0;

	ocht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_key),
		.divisor  (bc_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Chain walk decisions.
	assign cur_ok   = cur_q < NIL;
	assign prev_ok  = prev_q < NIL;
	assign walk_end = !cur_ok || (steps_q == SW'(POOL_NODES));
	assign key_eq   = key_rd == key_q;
	assign key_lt   = key_rd < key_q;
	assign cur_x    = XW'(cur_q[NI-1:0]);
	assign cur_word = WI'(cur_x >> 5);
	assign cur_bit  = cur_x[4:0];
	assign low_bit  = lowest_one(fw_rd);

	// Free-map word contents on a clear: only bits of existing nodes are set.
	assign sweep_base = {sweep_q, 5'b0};
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			clr_mask[b] = (32'(sweep_base) + 32'(b)) < 32'(POOL_NODES);
		end
	end

	// Memory write and read control.
	always_comb begin
		hd_we = 1'b0;
		hd_wa = HB'(h_q);
		hd_wd = n_q;
		nd_we = 1'b0;
		ln_we = 1'b0;
		ln_wa = n_q[NI-1:0];
		ln_wd = cur_q;
		fw_we = 1'b0;
		fw_wa = w_q;
		fw_wd = fw_rd & ~(32'd1 << low_bit);
		fw_ra = w_q;
		case (state_q)
			S_CLR: begin
				hd_we = 32'(sweep_q) < 32'(MAX_BUCKETS);
				hd_wa = HB'(sweep_q);
				hd_wd = NIL;
				fw_we = 32'(sweep_q) < 32'(NWORDS);
				fw_wa = WI'(sweep_q);
				fw_wd = clr_mask;
			end
			S_NCHK: begin
				if (func_q == FN_DELETE && key_eq) begin
					hd_we = !prev_ok;
					hd_wd = link_rd;
					ln_we = prev_ok;
					ln_wa = prev_q[NI-1:0];
					ln_wd = link_rd;
				end
			end
			S_FCHK: begin
				fw_we = fw_rd != '0;
			end
			S_INS1: begin
				nd_we = 1'b1;
				ln_we = 1'b1;
			end
			S_INS2: begin
				hd_we = !prev_ok;
				ln_we = prev_ok;
				ln_wa = prev_q[NI-1:0];
				ln_wd = n_q;
			end
			S_FREL_RD: begin
				fw_ra = cur_word;
			end
			S_FREL_WR: begin
				fw_we = 1'b1;
				fw_wa = cur_word;
				fw_wd = fw_rd | (32'd1 << cur_bit);
			end
			default: begin
			end
		endcase
	end

	// Bucket head memory.
	always_ff @(posedge clk) begin
		if (hd_we) heads[hd_wa] <= hd_wd;
		hd_rd <= heads[HB'(h_q)];
	end

	// Node memories, read at the current chain node.
	always_ff @(posedge clk) begin
		if (nd_we) begin
			key_mem[n_q[NI-1:0]] <= key_q;
			tag_mem[n_q[NI-1:0]] <= tag_q;
		end
		key_rd <= key_mem[cur_q[NI-1:0]];
		tag_rd <= tag_mem[cur_q[NI-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ln_we) link_mem[ln_wa] <= ln_wd;
		link_rd <= link_mem[cur_q[NI-1:0]];
	end

	// Free-node map, 32 nodes per word, a set bit marks a free node.
	always_ff @(posedge clk) begin
		if (fw_we) free_mem[fw_wa] <= fw_wd;
		fw_rd <= free_mem[fw_ra];
	end

	// Sequencer with result and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clr_pend_q <= 1'b1;
			clr_rsp_q  <= 1'b0;
			sweep_q    <= '0;
			bc_q       <= BC_W'(MAX_BUCKETS < 256 ? MAX_BUCKETS : 256);
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (cfg_we) begin
				clr_pend_q <= 1'b1;
				if (pwdata[BC_W-1:0] == '0) begin
					bc_q <= BC_W'(1);
				end else if (32'(pwdata[BC_W-1:0]) > 32'(MAX_BUCKETS)) begin
					bc_q <= BC_W'(MAX_BUCKETS);
				end else begin
					bc_q <= pwdata[BC_W-1:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (clr_pend_q) begin
						if (!cfg_we) clr_pend_q <= 1'b0;
						clr_rsp_q <= 1'b0;
						sweep_q   <= '0;
						state_q   <= S_CLR;
					end else if (accept) begin
						func_q  <= s_tuser;
						key_q   <= in_key;
						tag_q   <= in_tag;
						succ_q  <= 1'b0;
						stat_q  <= STAT_DONE;
						found_q <= '0;
						bidx_q  <= '0;
						cnt_q   <= '0;
						if (s_tuser <= FN_DELETE) begin
							state_q <= S_DIV;
						end else if (s_tuser == FN_COUNT) begin
							bidx_q <= in_sel;
							h_q    <= BC_W'(in_sel);
							if (BC_W'(in_sel) < bc_q) begin
								state_q <= S_HEAD;
							end else begin
								state_q <= S_RESP;
							end
						end else if (s_tuser == FN_CLEAR) begin
							clr_rsp_q <= 1'b1;
							sweep_q   <= '0;
							state_q   <= S_CLR;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == CW'(SWEEP_N - 1)) begin
						state_q <= clr_rsp_q ? S_RESP : S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						h_q     <= div_rem;
						bidx_q  <= SEL_W'(div_rem);
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_HWAIT;
				end
				S_HWAIT: begin
					cur_q   <= hd_rd;
					prev_q  <= NIL;
					steps_q <= '0;
					state_q <= S_NRD;
				end
				S_NRD: begin
					if (walk_end) begin
						case (func_q)
							FN_INSERT: begin
								w_q     <= '0;
								state_q <= S_FRD;
							end
							FN_SEARCH, FN_DELETE: begin
								stat_q  <= STAT_MISS;
								state_q <= S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end else begin
						state_q <= S_NCHK;
					end
				end
				S_NCHK: begin
					// Advance to the next node unless this node ends the walk.
					prev_q  <= cur_q;
					cur_q   <= link_rd;
					steps_q <= steps_q + 1'b1;
					state_q <= S_NRD;
					case (func_q)
						FN_INSERT: begin
							if (key_eq) begin
								prev_q  <= prev_q;
								cur_q   <= cur_q;
								stat_q  <= STAT_MISS;
								state_q <= S_RESP;
							end else if (!key_lt) begin
								prev_q  <= prev_q;
								cur_q   <= cur_q;
								w_q     <= '0;
								state_q <= S_FRD;
							end
						end
						FN_SEARCH: begin
							if (key_eq) begin
								succ_q  <= 1'b1;
								found_q <= tag_rd;
								state_q <= S_RESP;
							end
						end
						FN_DELETE: begin
							if (key_eq) begin
								prev_q  <= prev_q;
								cur_q   <= cur_q;
								succ_q  <= 1'b1;
								state_q <= S_FREL_RD;
							end
						end
						default: begin
							if (cnt_q != {CNT_W{1'b1}}) cnt_q <= cnt_q + 1'b1;
						end
					endcase
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (fw_rd != '0) begin
						n_q     <= PW'({w_q, low_bit});
						state_q <= S_INS1;
					end else if (w_q == WI'(NWORDS - 1)) begin
						stat_q  <= STAT_FULL;
						state_q <= S_RESP;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_INS1: begin
					state_q <= S_INS2;
				end
				S_INS2: begin
					succ_q  <= 1'b1;
					state_q <= S_RESP;
				end
				S_FREL_RD: begin
					state_q <= S_FREL_WR;
				end
				S_FREL_WR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, cnt_q, bidx_q, found_q, stat_q, succ_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hdl/ocht_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered chained hash table port checker
// Watches the top level's ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
module ocht_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ocht_pkg::OUT_W-1:0]  m_tdata,
	input logic                        pready
);
	import ocht_pkg::*;

	// One item at a time: the block is busy right after taking an item.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on two consecutive cycles");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Status never goes past the pool-full code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:1] <= STAT_FULL)
		else $error("undefined status code");

	// A successful item always reports status done.
	a_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2:1] == STAT_DONE)
		else $error("success with a failing status");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ordered_chained_hash_table ocht_chk u_ocht_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
